// ===== rtl/csf_pkg.sv =====
// Shared types and constants for the 3x3 sharpening filter.
package csf_pkg;

   // Pixel and coordinate widths
   localparam int PIXEL_W = 8;
   localparam int COORD_W = 5;
   localparam int TAPS    = 9;

   // Kernel taps, row-major, and the bias added before the divide
   localparam int KERN_W = 5;
   localparam logic signed [KERN_W-1:0] KERNEL [TAPS] = '{
      -5'sd7,  5'sd5,  5'sd2,
      -5'sd1,  5'sd15, -5'sd1,
       5'sd2,  5'sd5, -5'sd7
   };
   localparam int SUM_W = 14;
   localparam logic signed [SUM_W-1:0] SUM_BIAS = 14'sd128;

   // Divide by 13 through a reciprocal: q = (sum * RECIP) >> SHIFT,
   // exact for 0 <= sum < 8192
   localparam int QUOT_IN_W  = 13;
   localparam int RECIP_W    = 14;
   localparam int DIV_SHIFT  = 17;
   localparam int PROD_W     = QUOT_IN_W + RECIP_W;
   localparam int QUOT_W     = PROD_W - DIV_SHIFT;
   localparam logic [RECIP_W-1:0] DIV_RECIP = 14'd10083;
   localparam logic [QUOT_W-1:0]  PIXEL_MAX = 10'd255;

   // Depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   // One interior window on its way to the arithmetic
   typedef struct packed {
      logic [TAPS-1:0][PIXEL_W-1:0] pixels;
      logic [COORD_W-1:0]           row;
      logic [COORD_W-1:0]           col;
      logic                         frame_done;
   } work_type;

endpackage

// ===== rtl/csf_req_if.sv =====
// Input pixel channel: valid/ready with one pixel per item.
interface csf_req_if;
   logic                        valid;
   logic                        ready;
   logic [csf_pkg::PIXEL_W-1:0] pixel_in;

   modport source (output valid, output pixel_in, input ready);
   modport sink   (input valid, input pixel_in, output ready);
endinterface

// ===== rtl/csf_rsp_if.sv =====
// Result channel: valid/ready with a filtered pixel and its coordinates.
interface csf_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [csf_pkg::PIXEL_W-1:0] pixel_out;
   logic [csf_pkg::COORD_W-1:0] out_row;
   logic [csf_pkg::COORD_W-1:0] out_col;
   logic                        frame_done;

   modport source (output valid, output pixel_out, output out_row, output out_col,
                   output frame_done, input ready);
   modport sink   (input valid, input pixel_out, input out_row, input out_col,
                   input frame_done, output ready);
endinterface

// ===== rtl/conv3x3_sharpen_filter_core.sv =====
// Top level of the streaming 3x3 sharpening filter.
//
//   channel   direction  payload                                   handshake
//   req_ch    in         pixel_in[7:0]                             valid/ready
//   rsp_ch    out        pixel_out[7:0], out_row, out_col, done    valid/ready
//
// One pixel is taken per clock when nothing stalls; an interior result is offered once
// its last pixel has passed through four registers:
// pixel stage with line store read, queue entry, sum, then divide and clip into
// the result register.
// The line store read and write-back of one column set the one-item-per-cycle rate.
// Reset is synchronous and clears counters, window and valid flags; the line
// store holds no reset and only feeds results after it is written.
// A stalled result port fills the back stages, then the two-entry queue, then
// stops the input; border pixels pass the front without using the queue.
module conv3x3_sharpen_filter_core #(
   parameter int IMAGE_WIDTH  = 32,
   parameter int IMAGE_HEIGHT = 32
) (
   input  logic       clock,
   input  logic       reset,
   csf_req_if.sink    req_ch,
   csf_rsp_if.source  rsp_ch
);

   logic              push_valid;
   logic              push_ready;
   csf_pkg::work_type push_item;
   logic              pop_valid;
   logic              pop_ready;
   csf_pkg::work_type pop_item;

   // Classify pixels and build windows
   csf_front #(
      .IMAGE_WIDTH  (IMAGE_WIDTH),
      .IMAGE_HEIGHT (IMAGE_HEIGHT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   // Buffer interior windows
   csf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   // Filter arithmetic and result register
   csf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .rsp_ch    (rsp_ch)
   );

endmodule

// ===== rtl/csf_front.sv =====
// Front end: raster counters, line store, 3x3 window and interior classification.
module csf_front #(
   parameter int IMAGE_WIDTH  = 32,
   parameter int IMAGE_HEIGHT = 32
) (
   input  logic              clock,
   input  logic              reset,
   csf_req_if.sink           req_ch,
   output logic              push_valid,
   input  logic              push_ready,
   output csf_pkg::work_type push_item
);

   localparam int CW  = $clog2(IMAGE_WIDTH);
   localparam int RW  = $clog2(IMAGE_HEIGHT);
   localparam int CXW = (CW > csf_pkg::COORD_W) ? CW : csf_pkg::COORD_W;
   localparam int RXW = (RW > csf_pkg::COORD_W) ? RW : csf_pkg::COORD_W;
   localparam int PW  = csf_pkg::PIXEL_W;
   localparam logic [CW-1:0] COL_LAST = CW'(IMAGE_WIDTH - 1);
   localparam logic [RW-1:0] ROW_LAST = RW'(IMAGE_HEIGHT - 1);

   // Position of the next incoming pixel
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;

   // Stage holding an accepted pixel while its line store read returns
   logic          s1_valid_ff, s1_valid_in;
   logic [PW-1:0] s1_px_ff;
   logic [CW-1:0] s1_col_ff;
   logic [RW-1:0] s1_row_ff;
   logic [2*PW-1:0] rd_ff;

   // Line store: upper byte is the row two above, lower byte the row one above
   logic [2*PW-1:0] line_mem [IMAGE_WIDTH];

   // 3x3 window, [row][col], column 2 newest
   logic [PW-1:0] win_ff [3][3];
   logic [PW-1:0] win_in [3][3];

   logic accept;
   logic s1_interior;
   logic s1_adv;
   logic [CXW-1:0] col_center;
   logic [RXW-1:0] row_center;

   assign accept      = req_ch.valid && req_ch.ready;
   assign s1_interior = (s1_row_ff >= RW'(2)) && (s1_col_ff >= CW'(2));
   assign s1_adv      = s1_valid_ff && (!s1_interior || push_ready);
   assign req_ch.ready = !s1_valid_ff || s1_adv;

   // Advance the raster position on each accepted item
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_ff == COL_LAST) begin
            col_in = '0;
            row_in = (row_ff == ROW_LAST) ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Capture the pixel and read the two rows above it
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff  <= req_ch.pixel_in;
         s1_col_ff <= col_ff;
         s1_row_ff <= row_ff;
         rd_ff     <= line_mem[col_ff];
      end
   end

   // Roll the column down the line store as the item leaves
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         line_mem[s1_col_ff] <= {rd_ff[PW-1:0], s1_px_ff};
      end
   end

   // Shift the window left and bring in the new column
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         win_in[i][0] = win_ff[i][1];
         win_in[i][1] = win_ff[i][2];
      end
      win_in[0][2] = rd_ff[2*PW-1:PW];
      win_in[1][2] = rd_ff[PW-1:0];
      win_in[2][2] = s1_px_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else if (s1_adv) begin
         win_ff <= win_in;
      end
   end

   // Hand interior windows to the queue, centered one row and column back
   assign col_center = CXW'(s1_col_ff) - CXW'(1);
   assign row_center = RXW'(s1_row_ff) - RXW'(1);

   assign push_valid = s1_valid_ff && s1_interior;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            push_item.pixels[i*3+j] = win_in[i][j];
         end
      end
      push_item.row        = row_center[csf_pkg::COORD_W-1:0];
      push_item.col        = col_center[csf_pkg::COORD_W-1:0];
      push_item.frame_done = (s1_row_ff == ROW_LAST) && (s1_col_ff == COL_LAST);
   end

endmodule

// ===== rtl/csf_queue.sv =====
// Two-entry queue that decouples the front end from the arithmetic.
module csf_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  csf_pkg::work_type push_item,
   output logic              pop_valid,
   input  logic              pop_ready,
   output csf_pkg::work_type pop_item
);

   csf_pkg::work_type entry_ff [csf_pkg::QUEUE_DEPTH];

   logic [csf_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [csf_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [csf_pkg::QCNT_W-1:0] count_ff, count_in;

   logic do_push;
   logic do_pop;

   assign push_ready = (count_ff != csf_pkg::QCNT_W'(csf_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Step pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + csf_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + csf_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + csf_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - csf_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed item
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/csf_back.sv =====
// Back end: kernel sum, divide by 13, clip and result register.
module csf_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  csf_pkg::work_type pop_item,
   csf_rsp_if.source         rsp_ch
);

   localparam int SW = csf_pkg::SUM_W;
   localparam int PW = csf_pkg::PIXEL_W;
   localparam int CD = csf_pkg::COORD_W;

   // Sum stage
   logic                 a_valid_ff, a_valid_in;
   logic signed [SW-1:0] a_sum_ff, a_sum_in;
   logic [CD-1:0]        a_row_ff;
   logic [CD-1:0]        a_col_ff;
   logic                 a_done_ff;

   // Result register
   logic                 out_valid_ff, out_valid_in;
   logic [PW-1:0]        out_px_ff, out_px_in;
   logic [CD-1:0]        out_row_ff;
   logic [CD-1:0]        out_col_ff;
   logic                 out_done_ff;

   logic a_ready;
   logic b_ready;
   logic a_load;
   logic b_load;
   logic [csf_pkg::PROD_W-1:0] prod;
   logic [csf_pkg::QUOT_W-1:0] quot;

   assign b_ready   = !out_valid_ff || rsp_ch.ready;
   assign a_ready   = !a_valid_ff || b_ready;
   assign pop_ready = a_ready;
   assign a_load    = pop_valid && a_ready;
   assign b_load    = a_valid_ff && b_ready;

   // Weighted sum of the window plus bias
   always_comb begin
      a_sum_in = csf_pkg::SUM_BIAS;
      for (int k = 0; k < csf_pkg::TAPS; k++) begin
         a_sum_in = a_sum_in + SW'(csf_pkg::KERNEL[k]) * SW'($signed({1'b0, pop_item.pixels[k]}));
      end
   end

   // Divide by 13 and clip; any negative sum ends at zero
   assign prod = csf_pkg::PROD_W'(a_sum_ff[csf_pkg::QUOT_IN_W-1:0])
               * csf_pkg::PROD_W'(csf_pkg::DIV_RECIP);
   assign quot = prod[csf_pkg::PROD_W-1:csf_pkg::DIV_SHIFT];

   always_comb begin
      priority if (a_sum_ff < 0) begin
         out_px_in = '0;
      end else if (quot > csf_pkg::PIXEL_MAX) begin
         out_px_in = csf_pkg::PIXEL_MAX[PW-1:0];
      end else begin
         out_px_in = quot[PW-1:0];
      end
   end

   // Valid flags of both stages
   always_comb begin
      a_valid_in = a_load ? 1'b1 : (b_load ? 1'b0 : a_valid_ff);
      if (b_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Hold payloads until their stage advances
   always_ff @(posedge clock) begin
      if (a_load) begin
         a_sum_ff  <= a_sum_in;
         a_row_ff  <= pop_item.row;
         a_col_ff  <= pop_item.col;
         a_done_ff <= pop_item.frame_done;
      end
      if (b_load) begin
         out_px_ff   <= out_px_in;
         out_row_ff  <= a_row_ff;
         out_col_ff  <= a_col_ff;
         out_done_ff <= a_done_ff;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.pixel_out  = out_px_ff;
   assign rsp_ch.out_row    = out_row_ff;
   assign rsp_ch.out_col    = out_col_ff;
   assign rsp_ch.frame_done = out_done_ff;

endmodule

// ===== sim/tb_conv3x3_sharpen_filter_core.sv =====
// Testbench for the 3x3 sharpening filter: directed and random pixels checked against a predictor.
`timescale 1ns / 1ps

module tb_conv3x3_sharpen_filter_core;

   localparam int FRAME_W      = 32;
   localparam int FRAME_H      = 32;
   localparam int DIRECTED_N   = 25;
   // Just over one frame, so the end of frame and the wrap into the next one are seen
   localparam int PIXEL_TOTAL  = FRAME_W * FRAME_H + 3 * FRAME_W;
   localparam int PHASE_LEN    = PIXEL_TOTAL / 3;
   localparam int DRAIN_PAUSE  = 500;
   localparam int HOLD_START   = 800;
   localparam int HOLD_CYCLES  = 150;
   localparam int SETTLE_CYC   = 20;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int REPORT_MAX   = 10;

   typedef struct {
      logic [csf_pkg::PIXEL_W-1:0] pixel;
      logic [csf_pkg::COORD_W-1:0] row;
      logic [csf_pkg::COORD_W-1:0] col;
      logic                        done;
   } sharp_result_type;

   // Predicts filtered pixels from accepted input pixels and checks arriving results
   class sharpen_scoreboard #(int WIDTH = 32, int HEIGHT = 32);
      int                          weight [9];
      logic [csf_pkg::PIXEL_W-1:0] upper_row [WIDTH];
      logic [csf_pkg::PIXEL_W-1:0] lower_row [WIDTH];
      logic [csf_pkg::PIXEL_W-1:0] win [3][3];
      int                          row_count;
      int                          col_count;
      sharp_result_type            expected_q [$];
      int                          mismatches;
      int                          results_seen;
      int                          frames_seen;
      int                          clip_low;
      int                          clip_high;

      function new();
         weight = '{-7, 5, 2, -1, 15, -1, 2, 5, -7};
         foreach (upper_row[i]) begin
            upper_row[i] = '0;
            lower_row[i] = '0;
         end
         foreach (win[i, j]) win[i][j] = '0;
         row_count    = 0;
         col_count    = 0;
         mismatches   = 0;
         results_seen = 0;
         frames_seen  = 0;
         clip_low     = 0;
         clip_high    = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Shift the pixel into line stores and window; queue a result for interior centers
      function void note_pixel(logic [csf_pkg::PIXEL_W-1:0] px);
         sharp_result_type            res;
         logic [csf_pkg::PIXEL_W-1:0] top;
         logic [csf_pkg::PIXEL_W-1:0] mid;
         int                          acc;
         int                          quot;
         top = upper_row[col_count];
         mid = lower_row[col_count];
         upper_row[col_count] = mid;
         lower_row[col_count] = px;
         for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
         end
         win[0][2] = top;
         win[1][2] = mid;
         win[2][2] = px;
         if (row_count >= 2 && col_count >= 2) begin
            acc = 128;
            for (int i = 0; i < 3; i++)
               for (int j = 0; j < 3; j++)
                  acc += weight[i*3 + j] * int'(win[i][j]);
            // Signed divide truncates toward zero, then clip
            quot = acc / 13;
            if (quot < 0) begin
               quot = 0;
               clip_low++;
            end
            if (quot > 255) begin
               quot = 255;
               clip_high++;
            end
            res.pixel = csf_pkg::PIXEL_W'(quot);
            res.row   = csf_pkg::COORD_W'(row_count - 1);
            res.col   = csf_pkg::COORD_W'(col_count - 1);
            res.done  = (row_count == HEIGHT - 1 && col_count == WIDTH - 1);
            expected_q.push_back(res);
         end
         // Advance raster position, wrap at end of frame
         col_count++;
         if (col_count >= WIDTH) begin
            col_count = 0;
            row_count++;
            if (row_count >= HEIGHT) row_count = 0;
         end
      endfunction

      // Compare a result with the oldest expectation, field by field
      function void check_result(sharp_result_type got);
         sharp_result_type want;
         results_seen++;
         if (got.done) frames_seen++;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("ERROR: unexpected result pixel=%0d row=%0d col=%0d done=%0b",
                        got.pixel, got.row, got.col, got.done);
            return;
         end
         want = expected_q.pop_front();
         if (got.pixel !== want.pixel || got.row !== want.row ||
             got.col !== want.col || got.done !== want.done) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
               $display("ERROR: result %0d exp pixel=%0d row=%0d col=%0d done=%0b",
                        results_seen, want.pixel, want.row, want.col, want.done);
               $display("       got pixel=%0d row=%0d col=%0d done=%0b",
                        got.pixel, got.row, got.col, got.done);
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   recv_idle_pct;
   int   accepted;
   int   hold_left;
   bit   hold_started;
   int   cycles;

   csf_req_if pixel_ch ();
   csf_rsp_if result_ch ();

   sharpen_scoreboard #(FRAME_W, FRAME_H) sb;

   conv3x3_sharpen_filter_core #(
      .IMAGE_WIDTH  (FRAME_W),
      .IMAGE_HEIGHT (FRAME_H)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (pixel_ch),
      .rsp_ch (result_ch)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Give up on a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results still expected", cycles, sb.pending());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Observe both handshakes; note the input before checking the output
   always @(posedge clock) begin
      sharp_result_type got;
      if (!reset) begin
         if (pixel_ch.valid && pixel_ch.ready) begin
            sb.note_pixel(pixel_ch.pixel_in);
            accepted <= accepted + 1;
         end
         if (result_ch.valid && result_ch.ready) begin
            got.pixel = result_ch.pixel_out;
            got.row   = result_ch.out_row;
            got.col   = result_ch.out_col;
            got.done  = result_ch.frame_done;
            sb.check_result(got);
         end
      end
   end

   // Count down one long receiver hold-off while the sender keeps offering items
   always @(posedge clock) begin
      if (!hold_started && accepted >= HOLD_START) begin
         hold_started <= 1'b1;
         hold_left    <= HOLD_CYCLES;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Drive result ready with random stalls
   always @(posedge clock) begin
      result_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Offer one pixel, idling at random first, and hold it until accepted
   task automatic send_pixel(input logic [csf_pkg::PIXEL_W-1:0] px);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         pixel_ch.valid <= 1'b0;
         @(posedge clock);
      end
      pixel_ch.valid    <= 1'b1;
      pixel_ch.pixel_in <= px;
      @(posedge clock);
      while (!pixel_ch.ready) @(posedge clock);
   endtask

   // Bias toward the extremes so that both clipping limits are reached
   function automatic logic [csf_pkg::PIXEL_W-1:0] pick_pixel();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 2) return '0;
      if (sel < 4) return '1;
      if (sel == 4) return csf_pkg::PIXEL_W'($urandom_range(0, 15));
      return csf_pkg::PIXEL_W'($urandom_range(0, 255));
   endfunction

   // Set idling for the part of the run that the item index falls in
   task automatic set_phase(input int idx);
      if (idx < PHASE_LEN) begin
         send_idle_pct = 12;
         recv_idle_pct = 79;
      end else if (idx < 2 * PHASE_LEN) begin
         send_idle_pct = 79;
         recv_idle_pct = 12;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   endtask

   initial begin
      logic [csf_pkg::PIXEL_W-1:0] directed [DIRECTED_N];
      int                          settle;
      directed = '{8'h00, 8'hFF, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40,
                   8'h80, 8'hFE, 8'hFD, 8'hFB, 8'hF7, 8'hEF, 8'hDF, 8'hBF, 8'h7F,
                   8'h55, 8'hAA, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h80};
      sb                 = new();
      cycles             = 0;
      accepted           = 0;
      hold_left          = 0;
      hold_started       = 1'b0;
      send_idle_pct      = 12;
      recv_idle_pct      = 79;
      reset              = 1'b1;
      pixel_ch.valid     = 1'b0;
      pixel_ch.pixel_in  = '0;
      result_ch.ready    = 1'b0;

      // Hold reset, then release it
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed pixels: field extremes and every single bit set and cleared
      for (int i = 0; i < DIRECTED_N; i++) begin
         set_phase(i);
         send_pixel(directed[i]);
      end

      // Random pixels through the rest of the frame and into the next
      for (int i = DIRECTED_N; i < PIXEL_TOTAL; i++) begin
         set_phase(i);
         if (i == DRAIN_PAUSE) begin
            pixel_ch.valid <= 1'b0;
            @(posedge clock);
            while (sb.pending() != 0) @(posedge clock);
         end
         send_pixel(pick_pixel());
      end
      pixel_ch.valid <= 1'b0;

      // Drain the outstanding results, then let the pipeline settle
      while (sb.pending() != 0) @(posedge clock);
      for (settle = 0; settle < SETTLE_CYC; settle++) @(posedge clock);

      $display("Fed %0d pixels, checked %0d filtered results over %0d completed frame(s)",
               accepted, sb.results_seen, sb.frames_seen);
      $display("Results clipped at zero: %0d, clipped at full scale: %0d, mismatches: %0d",
               sb.clip_low, sb.clip_high, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
